// File: sv/blit_rect_clip_defines.svh
// Assertion macros for the blit rectangle clipper.
`ifndef BLIT_RECT_CLIP_DEFINES_SVH
`define BLIT_RECT_CLIP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that a condition implies another in the same cycle
`define BRC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that a condition implies another in the next cycle
`define BRC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BRC_ASSERT_IMP(lbl, ante, cons, msg)
`define BRC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/brc_pkg.sv
// Shared types and constants of the blit rectangle clipper.
package brc_pkg;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_PITCH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DST_PITCH    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SAME_SURFACE = 3'd6;

	// field widths
	localparam int REQ_W   = 15;
	localparam int DIM_W   = 13;
	localparam int PITCH_W = 16;
	localparam int POS_W   = 12;
	localparam int SIZE_W  = 13;

	// working width of the clip arithmetic: holds every trimmed origin and sum
	localparam int CALC_W = 18;

	typedef logic signed [CALC_W-1:0] calc_t;

	typedef struct packed {
		logic [DIM_W-1:0]   src_width;
		logic [DIM_W-1:0]   src_height;
		logic [DIM_W-1:0]   dst_width;
		logic [DIM_W-1:0]   dst_height;
		logic [PITCH_W-1:0] src_pitch;
		logic [PITCH_W-1:0] dst_pitch;
		logic               same_surface;
	} cfg_t;

	typedef struct packed {
		logic signed [REQ_W-1:0] src_x;
		logic signed [REQ_W-1:0] src_y;
		logic signed [REQ_W-1:0] dst_x;
		logic signed [REQ_W-1:0] dst_y;
		logic signed [REQ_W-1:0] width;
		logic signed [REQ_W-1:0] height;
	} req_t;

	typedef struct packed {
		logic              copy_valid;
		logic [POS_W-1:0]  src_x;
		logic [POS_W-1:0]  src_y;
		logic [POS_W-1:0]  dst_x;
		logic [POS_W-1:0]  dst_y;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		logic              overlap;
		logic              bottom_up;
	} res_t;

endpackage

// File: sv/brc_cfg_regs.sv
// Configuration register file of the blit rectangle clipper.
module brc_cfg_regs
	import brc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// take a register write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:    cfg_q.src_width    <= cfg_data[DIM_W-1:0];
				REG_SRC_HEIGHT:   cfg_q.src_height   <= cfg_data[DIM_W-1:0];
				REG_DST_WIDTH:    cfg_q.dst_width    <= cfg_data[DIM_W-1:0];
				REG_DST_HEIGHT:   cfg_q.dst_height   <= cfg_data[DIM_W-1:0];
				REG_SRC_PITCH:    cfg_q.src_pitch    <= cfg_data[PITCH_W-1:0];
				REG_DST_PITCH:    cfg_q.dst_pitch    <= cfg_data[PITCH_W-1:0];
				REG_SAME_SURFACE: cfg_q.same_surface <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/brc_clip.sv
// Combinational clip of one blit command against both surfaces.
module brc_clip
	import brc_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  cfg_t cfg,
	input  req_t req,
	output res_t res
);

	localparam calc_t MAX_C = calc_t'(MAX_DIM);

	// clamp a surface dimension to the largest supported size
	function automatic calc_t limit_dim(input logic [DIM_W-1:0] v);
		calc_t d;
		d = calc_t'({{(CALC_W-DIM_W){1'b0}}, v});
		return (d > MAX_C) ? MAX_C : d;
	endfunction

	// widen a request field, keeping its sign
	function automatic calc_t sext(input logic signed [REQ_W-1:0] v);
		return {{(CALC_W-REQ_W){v[REQ_W-1]}}, v};
	endfunction

	always_comb begin
		calc_t sw, sh, dw, dh;
		calc_t sx, sy, dx, dy, w, h;
		logic  reject, ovl;

		sw = limit_dim(cfg.src_width);
		sh = limit_dim(cfg.src_height);
		dw = limit_dim(cfg.dst_width);
		dh = limit_dim(cfg.dst_height);

		sx = sext(req.src_x);
		sy = sext(req.src_y);
		dx = sext(req.dst_x);
		dy = sext(req.dst_y);
		w  = sext(req.width);
		h  = sext(req.height);

		reject = (cfg.src_pitch == '0) || (cfg.dst_pitch == '0)
		      || (w <= 0) || (h <= 0);

		// trim negative source origin, then negative destination origin
		if (sx < 0) begin
			dx = dx - sx;
			w  = w + sx;
			sx = '0;
		end
		if (sy < 0) begin
			dy = dy - sy;
			h  = h + sy;
			sy = '0;
		end
		if (dx < 0) begin
			sx = sx - dx;
			w  = w + dx;
			dx = '0;
		end
		if (dy < 0) begin
			sy = sy - dy;
			h  = h + dy;
			dy = '0;
		end

		// reject empty rectangles and origins off their surface
		reject = reject || (w <= 0) || (h <= 0)
		      || (sx >= sw) || (sy >= sh) || (dx >= dw) || (dy >= dh);

		// clamp size to the source, then to the destination
		if (sx + w > sw) w = sw - sx;
		if (sy + h > sh) h = sh - sy;
		if (dx + w > dw) w = dw - dx;
		if (dy + h > dh) h = dh - dy;
		reject = reject || (w <= 0) || (h <= 0);

		ovl = cfg.same_surface
		   && !((dx + w <= sx) || (sx + w <= dx) || (dy + h <= sy) || (sy + h <= dy));

		// a rejected command gives an all-zero result
		res = '0;
		if (!reject) begin
			res.copy_valid = 1'b1;
			res.src_x      = sx[POS_W-1:0];
			res.src_y      = sy[POS_W-1:0];
			res.dst_x      = dx[POS_W-1:0];
			res.dst_y      = dy[POS_W-1:0];
			res.width      = w[SIZE_W-1:0];
			res.height     = h[SIZE_W-1:0];
			res.overlap    = ovl;
			res.bottom_up  = ovl && (dy > sy);
		end
	end

endmodule

// File: sv/blit_rect_clip.sv
// Top level of the blit rectangle clipper: input register, clip, result register.
//
//  channel  handshake             payload
//  -------  --------------------  ---------------------------------------------
//  in       in_valid / in_ready   req_src_x/y, req_dst_x/y, req_width/height
//  out      out_valid / out_ready copy_valid, clip_*, areas_overlap, rows_bottom_up
//  cfg      cfg_we                cfg_index, cfg_data
//
// One command per cycle is sustained while out_ready is held high. A command is
// captured in the input register, clipped, and its result captured in the result
// register; the two registers bracket the single clip stage. Reset clears both
// stage valid flags and the configuration registers; the command and result
// registers are not reset and are only read behind their valid flags.
// A stall on the output holds the result register, and the input register
// fills behind it before in_ready drops.
`include "blit_rect_clip_defines.svh"
module blit_rect_clip
	import brc_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [REQ_W-1:0] req_src_x,
	input  logic signed [REQ_W-1:0] req_src_y,
	input  logic signed [REQ_W-1:0] req_dst_x,
	input  logic signed [REQ_W-1:0] req_dst_y,
	input  logic signed [REQ_W-1:0] req_width,
	input  logic signed [REQ_W-1:0] req_height,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    copy_valid,
	output logic [POS_W-1:0]        clip_src_x,
	output logic [POS_W-1:0]        clip_src_y,
	output logic [POS_W-1:0]        clip_dst_x,
	output logic [POS_W-1:0]        clip_dst_y,
	output logic [SIZE_W-1:0]       clip_width,
	output logic [SIZE_W-1:0]       clip_height,
	output logic                    areas_overlap,
	output logic                    rows_bottom_up
);

	cfg_t cfg;
	req_t req_s1;
	res_t res_s2;
	res_t clip_res;
	logic valid_s1;
	logic valid_s2;
	logic adv_s1;
	logic adv_s2;

	brc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	brc_clip #(
		.MAX_DIM (MAX_DIM)
	) u_clip (
		.cfg (cfg),
		.req (req_s1),
		.res (clip_res)
	);

	// advance each stage when it is empty or the stage after it takes its contents
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// capture the command on transfer, the result when it moves on
	always_ff @(posedge clk) begin
		if (in_valid && adv_s1) begin
			req_s1 <= '{src_x: req_src_x, src_y: req_src_y,
			            dst_x: req_dst_x, dst_y: req_dst_y,
			            width: req_width, height: req_height};
		end
		if (valid_s1 && adv_s2) res_s2 <= clip_res;
	end

	assign out_valid      = valid_s2;
	assign copy_valid     = res_s2.copy_valid;
	assign clip_src_x     = res_s2.src_x;
	assign clip_src_y     = res_s2.src_y;
	assign clip_dst_x     = res_s2.dst_x;
	assign clip_dst_y     = res_s2.dst_y;
	assign clip_width     = res_s2.width;
	assign clip_height    = res_s2.height;
	assign areas_overlap  = res_s2.overlap;
	assign rows_bottom_up = res_s2.bottom_up;

	`BRC_ASSERT_NXT(a_in_lands, in_valid && in_ready, valid_s1, "accepted command lost")
	`BRC_ASSERT_IMP(a_reject_zero, out_valid && !copy_valid,
		clip_width == '0 && clip_height == '0 && !areas_overlap,
		"rejected result not cleared")
	`BRC_ASSERT_IMP(a_valid_size, out_valid && copy_valid,
		clip_width != '0 && clip_height != '0, "valid copy with empty size")
	`BRC_ASSERT_IMP(a_bup_ovl, out_valid && rows_bottom_up,
		areas_overlap && copy_valid, "bottom-up without overlap")

endmodule
